// ----- design/ngs_pkg.sv -----
// shared constants and types for the next greater element stack
package ngs_pkg;

	// fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int POS_W    = 6;

	// parameter defaults
	localparam int MAX_LEN_DEF    = 64;
	localparam int VALUE_BITS_DEF = 16;

	// one result request from the controller to the output stage
	typedef struct packed {
		logic             emit;
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] distance;
		logic             run_last;
	} ngs_res_t;

endpackage

// ----- design/ngs_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
module ngs_ram #(
	parameter int WIDTH = 22,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port; read data holds when no read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/ngs_out.sv -----
// output register stage for result requests
module ngs_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ngs_pkg::ngs_res_t          res,
	output logic                       out_free,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [ngs_pkg::POS_W-1:0]  position,
	output logic [ngs_pkg::POS_W-1:0]  distance,
	output logic                       run_last
);

	logic                      valid_q;
	logic [ngs_pkg::POS_W-1:0] position_q;
	logic [ngs_pkg::POS_W-1:0] distance_q;
	logic                      run_last_q;

	// register is free when empty or being taken this cycle
	assign out_free = !valid_q || !result_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.emit) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (res.emit) begin
			position_q <= res.position;
			distance_q <= res.distance;
			run_last_q <= res.run_last;
		end
	end

	assign result_valid = valid_q;
	assign position     = position_q;
	assign distance     = distance_q;
	assign run_last     = run_last_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.emit |-> (!valid_q || !result_stall))
		else $error("result request while output register is held");
`endif

endmodule

// ----- design/ngs_ctrl.sv -----
// stack controller: compare, pop, push and flush sequencing over the stack ram
module ngs_ctrl #(
	parameter int MAX_LEN    = ngs_pkg::MAX_LEN_DEF,
	parameter int VALUE_BITS = ngs_pkg::VALUE_BITS_DEF,
	localparam int VAL_W     = (VALUE_BITS < ngs_pkg::SAMPLE_W) ? VALUE_BITS : ngs_pkg::SAMPLE_W,
	localparam int ENT_W     = ngs_pkg::POS_W + VAL_W,
	localparam int AW        = $clog2(MAX_LEN)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic [ngs_pkg::SAMPLE_W-1:0]  sample_value,
	input  logic                          end_of_sequence,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic [ENT_W-1:0]              wr_data,
	output logic                          rd_en,
	output logic [AW-1:0]                 rd_addr,
	input  logic [ENT_W-1:0]              rd_data,
	input  logic                          out_free,
	output ngs_pkg::ngs_res_t             res
);

	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int POS_W = ngs_pkg::POS_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_PUSH,
		ST_FLUSH_RD,
		ST_FLUSH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [POS_W-1:0] npos_q;
	logic             pend_valid_q;
	logic [AW-1:0]    idx_q;

	logic [VAL_W-1:0] v_q;
	logic [POS_W-1:0] pos_q;
	logic             flush_q;
	logic [POS_W-1:0] pend_pos_q;
	logic [POS_W-1:0] pend_dist_q;

	logic             accept;
	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W-1:0] cnt_m2;
	logic [POS_W-1:0] top_pos;
	logic [VAL_W-1:0] top_val;
	logic             pop;
	logic             go;
	logic             flush_end;
	logic             seq_end;

	assign accept     = sample_valid && (state_q == ST_IDLE);
	assign sample_stall = (state_q != ST_IDLE);
	assign cnt_m1     = cnt_q - CNT_W'(1);
	assign cnt_m2     = cnt_q - CNT_W'(2);
	assign top_pos    = rd_data[ENT_W-1 -: POS_W];
	assign top_val    = rd_data[VAL_W-1:0];
	assign pop        = top_val < v_q;
	assign go         = !pend_valid_q || out_free;
	assign flush_end  = (CNT_W'(idx_q) == cnt_m1);
	assign seq_end    = end_of_sequence || (npos_q == POS_W'(MAX_LEN - 1));

	// ram access and result requests; reads and writes never hit the same entry at once
	always_comb begin
		rd_en        = 1'b0;
		rd_addr      = cnt_m1[AW-1:0];
		wr_en        = 1'b0;
		wr_addr      = cnt_q[AW-1:0];
		wr_data      = {pos_q, v_q};
		res.emit     = 1'b0;
		res.position = pend_pos_q;
		res.distance = pend_dist_q;
		res.run_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (cnt_q != '0)) begin
					rd_en = 1'b1;
				end
			end
			ST_CMP: begin
				if (pop && go) begin
					res.emit = pend_valid_q;
					if (cnt_q > CNT_W'(1)) begin
						rd_en   = 1'b1;
						rd_addr = cnt_m2[AW-1:0];
					end
				end
			end
			ST_PUSH: begin
				if (go) begin
					wr_en        = (cnt_q < CNT_W'(MAX_LEN));
					res.emit     = pend_valid_q;
					res.run_last = !flush_q;
				end
			end
			ST_FLUSH_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_q;
			end
			ST_FLUSH: begin
				if (out_free) begin
					res.emit     = 1'b1;
					res.position = top_pos;
					res.distance = '0;
					res.run_last = flush_end;
					if (!flush_end) begin
						rd_en   = 1'b1;
						rd_addr = idx_q + AW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// state machine and stack counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			npos_q       <= '0;
			pend_valid_q <= 1'b0;
			idx_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (cnt_q != '0) ? ST_CMP : ST_PUSH;
					end
				end
				ST_CMP: begin
					if (!pop) begin
						state_q <= ST_PUSH;
					end else if (go) begin
						pend_valid_q <= 1'b1;
						cnt_q        <= cnt_m1;
						if (cnt_q == CNT_W'(1)) begin
							state_q <= ST_PUSH;
						end
					end
				end
				ST_PUSH: begin
					if (go) begin
						pend_valid_q <= 1'b0;
						if (cnt_q < CNT_W'(MAX_LEN)) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (flush_q) begin
							idx_q   <= '0;
							state_q <= ST_FLUSH_RD;
						end else begin
							npos_q  <= npos_q + POS_W'(1);
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FLUSH_RD: begin
					state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					if (out_free) begin
						if (flush_end) begin
							cnt_q   <= '0;
							npos_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item payload and pending pop result
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q     <= sample_value[VAL_W-1:0];
			pos_q   <= npos_q;
			flush_q <= seq_end;
		end
		if ((state_q == ST_CMP) && pop && go) begin
			pend_pos_q  <= top_pos;
			pend_dist_q <= pos_q - top_pos;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_LEN))
		else $error("stack count above depth");
	a_cmp_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (cnt_q != '0))
		else $error("compare with empty stack");
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("pending pop result left behind in idle");
	a_flush_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (CNT_W'(idx_q) < cnt_q))
		else $error("flush index past stack top");
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FLUSH) && out_free && flush_end) |=> (cnt_q == '0 && npos_q == '0))
		else $error("stack not cleared after flush");
`endif

endmodule

// ----- design/next_greater_element_stack.sv -----
// Next greater element over a streamed sequence, using a monotonic stack in ram.
//
// Input channel (sample_valid / sample_stall): one request per sequence element,
// carrying sample_value and end_of_sequence. The element at position MAX_LEN-1
// also ends the sequence.
// Output channel (result_valid / result_stall): one request per settled position,
// with position, distance (0 = no greater value) and run_last on the final
// result caused by an element.
// Sequencing: an element is compared with the stack top, pops each smaller
// entry in turn and is then pushed; the compare is skipped when the stack is
// empty. On end of sequence the stack is then flushed bottom to top, one result
// per entry; each compare, pop or flush step is one read of the stack ram's
// single, registered read port. Each entry is pushed once and popped or flushed
// once. sample_stall is high while an element is in work.
// A stalled output holds its register; the pop and flush sequencing waits on it.
// Reset empties the stack and sets the position counter to zero; stack ram
// contents are left as they are and need no clearing.
module next_greater_element_stack #(
	parameter int MAX_LEN    = ngs_pkg::MAX_LEN_DEF,
	parameter int VALUE_BITS = ngs_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic [ngs_pkg::SAMPLE_W-1:0]  sample_value,
	input  logic                          end_of_sequence,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [ngs_pkg::POS_W-1:0]     position,
	output logic [ngs_pkg::POS_W-1:0]     distance,
	output logic                          run_last
);

	localparam int VAL_W = (VALUE_BITS < ngs_pkg::SAMPLE_W) ? VALUE_BITS : ngs_pkg::SAMPLE_W;
	localparam int ENT_W = ngs_pkg::POS_W + VAL_W;
	localparam int AW    = $clog2(MAX_LEN);

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [ENT_W-1:0]  wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [ENT_W-1:0]  rd_data;
	logic              out_free;
	ngs_pkg::ngs_res_t res;

	// stack storage: position and value per entry
	ngs_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_LEN)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// stack sequencing
	ngs_ctrl #(
		.MAX_LEN    (MAX_LEN),
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_valid    (sample_valid),
		.sample_stall    (sample_stall),
		.sample_value    (sample_value),
		.end_of_sequence (end_of_sequence),
		.wr_en           (wr_en),
		.wr_addr         (wr_addr),
		.wr_data         (wr_data),
		.rd_en           (rd_en),
		.rd_addr         (rd_addr),
		.rd_data         (rd_data),
		.out_free        (out_free),
		.res             (res)
	);

	// result register
	ngs_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res          (res),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.position     (position),
		.distance     (distance),
		.run_last     (run_last)
	);

endmodule

// ----- sim/tb.sv -----
// testbench for the next greater element stack: random sequences against a stack predictor
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_W       = ngs_pkg::SAMPLE_W;
	localparam int POS_W          = ngs_pkg::POS_W;
	localparam int MAX_LEN_DEF    = ngs_pkg::MAX_LEN_DEF;
	localparam int VALUE_BITS_DEF = ngs_pkg::VALUE_BITS_DEF;

	localparam int STACK_DEPTH = 64;
	localparam int RUN_ITEMS   = 260;
	localparam int QUIET_FROM  = 220;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 80;
	localparam bit [SAMPLE_W-1:0] VALUE_MASK =
		(VALUE_BITS_DEF >= SAMPLE_W) ? '1 : SAMPLE_W'((1 << VALUE_BITS_DEF) - 1);

	// shapes of value runs
	typedef enum int {
		SHAPE_WIDE,
		SHAPE_NARROW,
		SHAPE_EXTREME,
		SHAPE_FALLING
	} value_shape_t;

	// tracks the stack and holds the answers still to come out
	class next_greater_tracker;
		typedef struct {
			bit [POS_W-1:0] position;
			bit [POS_W-1:0] distance;
			bit             run_last;
		} settled_t;

		bit [POS_W-1:0]    stk_pos [STACK_DEPTH];
		bit [SAMPLE_W-1:0] stk_val [STACK_DEPTH];
		int                depth;
		bit [POS_W-1:0]    next_pos;
		settled_t          settled_q[$];
		int                errors;

		function new();
			depth    = 0;
			next_pos = 0;
			errors   = 0;
		endfunction

		// work out the answers that one accepted request settles
		function void note_sample(bit [SAMPLE_W-1:0] value, bit eos);
			bit [SAMPLE_W-1:0] v;
			bit [POS_W-1:0]    pos;
			settled_t          s;
			int                k;
			v   = value & VALUE_MASK;
			pos = next_pos;
			k   = 0;
			// strictly smaller entries are settled by this value
			while (depth > 0 && stk_val[depth-1] < v) begin
				s.position = stk_pos[depth-1];
				s.distance = pos - stk_pos[depth-1];
				s.run_last = 1'b0;
				settled_q.push_back(s);
				k++;
				depth--;
			end
			if (depth < STACK_DEPTH) begin
				stk_pos[depth] = pos;
				stk_val[depth] = v;
				depth++;
			end
			// end of sequence or length limit: flush bottom to top
			if (eos || int'(pos) + 1 >= MAX_LEN_DEF) begin
				for (int i = 0; i < depth; i++) begin
					s.position = stk_pos[i];
					s.distance = '0;
					s.run_last = 1'b0;
					settled_q.push_back(s);
					k++;
				end
				depth    = 0;
				next_pos = '0;
			end else begin
				next_pos = pos + 1'b1;
			end
			if (k > 0)
				settled_q[$].run_last = 1'b1;
		endfunction

		// compare one accepted result with the oldest answer waiting
		function void check_settled(bit [POS_W-1:0] p, bit [POS_W-1:0] d, bit last);
			settled_t want;
			if (settled_q.size() == 0) begin
				$display("%0t: unexpected result position %0d distance %0d run_last %0b",
					$time, p, d, last);
				errors++;
				return;
			end
			want = settled_q.pop_front();
			if (want.position != p) begin
				$display("%0t: position expected %0d actual %0d", $time, want.position, p);
				errors++;
			end
			if (want.distance != d) begin
				$display("%0t: distance expected %0d actual %0d (position %0d)",
					$time, want.distance, d, want.position);
				errors++;
			end
			if (want.run_last != last) begin
				$display("%0t: run_last expected %0b actual %0b (position %0d)",
					$time, want.run_last, last, want.position);
				errors++;
			end
		endfunction

		function int pending();
			return settled_q.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n          = 1'b0;
	logic                sample_valid    = 1'b0;
	logic                sample_stall;
	logic [SAMPLE_W-1:0] sample_value    = '0;
	logic                end_of_sequence = 1'b0;
	logic                result_valid;
	logic                result_stall    = 1'b0;
	logic [POS_W-1:0]    position;
	logic [POS_W-1:0]    distance;
	logic                run_last;

	next_greater_tracker tracker;
	int                  sent      = 0;
	int                  idle_pct  = 30;
	int                  stall_pct = 30;
	int unsigned         cycle_count = 0;

	next_greater_element_stack #(
		.MAX_LEN   (MAX_LEN_DEF),
		.VALUE_BITS(VALUE_BITS_DEF)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample_value   (sample_value),
		.end_of_sequence(end_of_sequence),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.position       (position),
		.distance       (distance),
		.run_last       (run_last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run time limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb failed");
		$finish;
	end

	// result side stalls in bursts
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && $urandom_range(0, 99) < stall_pct) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// check every accepted result
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			tracker.check_settled(position, distance, run_last);
	end

	// present one request and hold it until accepted
	task automatic send_sample(bit [SAMPLE_W-1:0] value, bit eos);
		if (sent >= QUIET_FROM) begin
			idle_pct  = 0;
			stall_pct = 0;
		end
		if ($urandom_range(0, 99) < idle_pct) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		sample_valid    <= 1'b1;
		sample_value    <= value;
		end_of_sequence <= eos;
		do
			@(posedge clk);
		while (sample_stall);
		tracker.note_sample(value, eos);
		sent++;
	endtask

	// send len values; noisy runs may carry a stray end marker before the last value
	task automatic send_run(int len, value_shape_t shape, bit close, bit noisy);
		bit [SAMPLE_W-1:0] level;
		bit [SAMPLE_W-1:0] v;
		bit                eos;
		level = '1;
		for (int i = 0; i < len; i++) begin
			case (shape)
				SHAPE_WIDE:   v = SAMPLE_W'($urandom_range(0, 65535));
				SHAPE_NARROW: v = SAMPLE_W'($urandom_range(0, 3));
				SHAPE_EXTREME: begin
					case ($urandom_range(0, 2))
						0:       v = '0;
						1:       v = '1;
						default: v = SAMPLE_W'($urandom_range(0, 65535));
					endcase
				end
				default: begin
					// non-increasing values build a deep stack
					v = level;
					if (level > 40)
						level = level - SAMPLE_W'($urandom_range(0, 40));
				end
			endcase
			if (i == len - 1)
				eos = close;
			else
				eos = noisy && $urandom_range(0, 19) == 0;
			send_sample(v, eos);
		end
	endtask

	// main sequence
	initial begin
		value_shape_t shape;
		int           len;
		bit           first_run;
		tracker   = new();
		first_run = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single element sequences at both extremes
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'h0000, 1'b1);
		// equal values stay stacked, a maximum pops everything
		send_sample(16'h8000, 1'b0);
		send_sample(16'h4000, 1'b0);
		send_sample(16'h4000, 1'b0);
		send_sample(16'h0001, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h1234, 1'b1);
		// alternating bit patterns and a flush of equal values
		send_sample(16'h5555, 1'b0);
		send_sample(16'hAAAA, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'h0000, 1'b1);
		// end of sequence on an element that pops first
		send_sample(16'd3, 1'b0);
		send_sample(16'd2, 1'b0);
		send_sample(16'd1, 1'b0);
		send_sample(16'd9, 1'b1);

		// random sequences
		while (sent < RUN_ITEMS) begin
			if (sent < QUIET_FROM) begin
				idle_pct  = $urandom_range(0, 2) * 30;
				stall_pct = $urandom_range(0, 2) * 30;
			end
			if (first_run) begin
				// full length falling run: ends on the length limit with a deep flush
				send_run(MAX_LEN_DEF, SHAPE_FALLING, 1'b0, 1'b0);
				first_run = 1'b0;
			end else begin
				shape = value_shape_t'($urandom_range(0, 3));
				if ($urandom_range(0, 15) == 0)
					len = $urandom_range(MAX_LEN_DEF - 4, MAX_LEN_DEF + 6);
				else
					len = $urandom_range(1, 12);
				send_run(len, shape, $urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0);
			end
		end
		sample_valid <= 1'b0;

		// drain
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ----- files.f -----
design/ngs_pkg.sv
design/ngs_ram.sv
design/ngs_out.sv
design/ngs_ctrl.sv
design/next_greater_element_stack.sv
sim/tb.sv
